FILE: rtl/ffgcd_pkg.sv
// Shared types, constants and a helper function for the frame gain command decoder.
package ffgcd_pkg;

    localparam int FRAME_LEN  = 10;
    localparam int FILL_W     = $clog2(FRAME_LEN + 1);
    localparam int NUM_DIGITS = 6;
    localparam int STEP_W     = $clog2(NUM_DIGITS + 1);
    localparam int GAIN_W     = 26;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] ASCII_O    = 8'h4F;

    localparam logic [3:0] GAIN_INDEX_UNKNOWN = 4'hF;

    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_TAIL   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEEK,
        ST_DECODE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load_byte;
        logic              shift;
        logic              clear_acc;
        logic              prod_en;
        logic              acc_en;
        logic [STEP_W-1:0] step;
        logic              load_out;
        logic              clear_fill;
    } dp_cmd_t;

    typedef struct packed {
        logic last_slot;
        logic frame_ok;
        logic seek_done;
        logic out_free;
    } dp_status_t;

    // Decimal weight of each digit step, in thousandths.
    function automatic logic signed [GAIN_W-1:0] digit_weight(input logic [STEP_W-1:0] step);
        logic signed [GAIN_W-1:0] w;
        case (step)
            STEP_W'(0): w = GAIN_W'(100000);
            STEP_W'(1): w = GAIN_W'(10000);
            STEP_W'(2): w = GAIN_W'(1000);
            STEP_W'(3): w = GAIN_W'(100);
            STEP_W'(4): w = GAIN_W'(10);
            STEP_W'(5): w = GAIN_W'(1);
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/ffgcd_datapath.sv
// Window store, frame compare, digit accumulator and output register.
module ffgcd_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic [7:0]                      rx_byte,
    input  ffgcd_pkg::dp_cmd_t              cmd,
    output ffgcd_pkg::dp_status_t           status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            target_known,
    output logic [3:0]                      gain_index,
    output logic signed [ffgcd_pkg::GAIN_W-1:0] gain_value
);
    import ffgcd_pkg::*;

    logic [7:0]               window_reg [FRAME_LEN];
    logic [FILL_W-1:0]        fill_reg;
    logic [7:0]               header_reg;
    logic [7:0]               tail_reg;
    logic signed [GAIN_W-1:0] prod_reg;
    logic signed [GAIN_W-1:0] prod_next;
    logic signed [GAIN_W-1:0] acc_reg;
    logic                     out_valid_reg;
    logic                     target_known_reg;
    logic [3:0]               gain_index_reg;
    logic signed [GAIN_W-1:0] gain_value_reg;

    logic [7:0]               digit_byte;
    logic signed [8:0]        digit_val;
    logic signed [GAIN_W-1:0] digit_ext;
    logic                     sel_known;
    logic [7:0]               sel_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            tail_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data;
                CFG_TAIL:   tail_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                if (fill_reg == FILL_W'(i))
                begin
                    window_reg[i] <= rx_byte;
                end
            end
        end
        else if (cmd.shift)
        begin
            // drop the oldest byte
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.clear_fill)
        begin
            fill_reg <= '0;
        end
        else if (cmd.load_byte)
        begin
            fill_reg <= fill_reg + FILL_W'(1);
        end
        else if (cmd.shift)
        begin
            fill_reg <= fill_reg - FILL_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.step)
            STEP_W'(0): digit_byte = window_reg[2];
            STEP_W'(1): digit_byte = window_reg[3];
            STEP_W'(2): digit_byte = window_reg[4];
            STEP_W'(3): digit_byte = window_reg[6];
            STEP_W'(4): digit_byte = window_reg[7];
            STEP_W'(5): digit_byte = window_reg[8];
            default:    digit_byte = ASCII_ZERO;
        endcase
        digit_val = $signed({1'b0, digit_byte}) - $signed({1'b0, ASCII_ZERO});
        digit_ext = GAIN_W'(digit_val);
        prod_next = digit_ext * digit_weight(cmd.step);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign sel_known  = (window_reg[1] >= ASCII_A) && (window_reg[1] <= ASCII_O);
    assign sel_offset = window_reg[1] - ASCII_A;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            target_known_reg <= sel_known;
            gain_index_reg   <= sel_known ? sel_offset[3:0] : GAIN_INDEX_UNKNOWN;
            gain_value_reg   <= acc_reg;
        end
    end

    assign status.last_slot = (fill_reg == FILL_W'(FRAME_LEN - 1));
    assign status.frame_ok  = (window_reg[0] == header_reg)
                            && (window_reg[FRAME_LEN-1] == tail_reg);
    assign status.seek_done = (fill_reg == '0) || (window_reg[0] == header_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign target_known = target_known_reg;
    assign gain_index   = gain_index_reg;
    assign gain_value   = gain_value_reg;

endmodule

FILE: rtl/ffgcd_ctrl.sv
// Sequencer for byte intake, frame check, header search and digit decode.
module ffgcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ffgcd_pkg::dp_status_t status,
    output ffgcd_pkg::dp_cmd_t    cmd
);
    import ffgcd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.last_slot)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.frame_ok ? ST_DECODE : ST_SEEK;
            end
            ST_SEEK:
            begin
                if (status.seek_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DECODE:
            begin
                if (step_reg == STEP_W'(NUM_DIGITS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.step  = step_reg;
        step_next = step_reg;
        in_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_byte = in_valid;
            end
            ST_CHECK:
            begin
                step_next = '0;
                if (status.frame_ok)
                begin
                    cmd.clear_acc = 1'b1;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            ST_SEEK:
            begin
                cmd.shift = !status.seek_done;
            end
            ST_DECODE:
            begin
                // product of one step is added in the next
                cmd.prod_en = (step_reg < STEP_W'(NUM_DIGITS));
                cmd.acc_en  = (step_reg != '0);
                step_next   = step_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                cmd.load_out   = status.out_free;
                cmd.clear_fill = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/fixed_frame_gain_command_decoder.sv
// Top level: fixed-length frame sync and gain command decoder.
// Throughput: one byte per cycle while the window fills.
// A full window is compared first, then shifted in a header search on a mismatch, or
// decoded (one digit multiply per cycle, shared multiplier) and loaded into the output
// register on a match; the output load waits while a pending result is stalled.
// Reset (rst_n, async): window empty, header and tail bytes 0, no result pending.
module fixed_frame_gain_command_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                target_known,
    output logic [3:0]                          gain_index,
    output logic signed [ffgcd_pkg::GAIN_W-1:0] gain_value
);
    import ffgcd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ffgcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ffgcd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_known (target_known),
        .gain_index   (gain_index),
        .gain_value   (gain_value)
    );

endmodule

FILE: dv/fixed_frame_gain_command_decoder_tb.sv
// Testbench for the fixed-length frame sync and gain command decoder.
module fixed_frame_gain_command_decoder_tb;

    import ffgcd_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_POS       = 6;
    localparam int DIGIT_POS [NUM_POS] = '{2, 3, 4, 6, 7, 8};
    localparam int DIGIT_WT  [NUM_POS] = '{100000, 10000, 1000, 100, 10, 1};

    typedef struct packed {
        logic                     known;
        logic [3:0]               idx;
        logic signed [GAIN_W-1:0] value;
    } gain_cmd_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic                     cfg_index;
    logic [7:0]               cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               rx_byte;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     target_known;
    logic [3:0]               gain_index;
    logic signed [GAIN_W-1:0] gain_value;

    // Frame tracker state: window copy, fill level, register copies
    logic [7:0] win_bytes [FRAME_LEN];
    int         win_fill;
    logic [7:0] hdr_reg;
    logic [7:0] tail_reg;

    gain_cmd_t  expected_cmds [$];
    gain_cmd_t  want;
    logic [7:0] frame_buf [FRAME_LEN];
    int         mismatch_count;
    int         bytes_sent;
    int         idle_pct;
    int         stall_pct;
    logic       hold_on;
    event       hold_start;

    fixed_frame_gain_command_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .target_known (target_known),
        .gain_index   (gain_index),
        .gain_value   (gain_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Hold the output off for a long stretch on request
    initial
    begin
        int cnt;
        hold_on = 1'b0;
        forever
        begin
            @(hold_start);
            @(posedge clk);
            hold_on = 1'b1;
            for (cnt = 0; cnt < HOLD_CYCLES; cnt++)
                @(posedge clk);
            hold_on = 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $write("mismatch (%s): expected known=%0d index=%0d value=%0d",
                   what, want.known, want.idx, want.value);
            $display(", got known=%0d index=%0d value=%0d",
                     target_known, gain_index, gain_value);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected result");
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (target_known !== want.known || gain_index !== want.idx ||
                    gain_value !== want.value)
                    note_mismatch("field");
            end
        end
    end

    // Advance the window by one byte; queue a gain command on a matching frame
    function automatic void track_byte(input logic [7:0] b);
        int        k;
        int        skip;
        longint    acc;
        gain_cmd_t cmd;
        if (win_fill >= FRAME_LEN)
            win_fill = 0;
        win_bytes[win_fill] = b;
        win_fill++;
        if (win_fill < FRAME_LEN)
            return;
        if (win_bytes[0] == hdr_reg && win_bytes[FRAME_LEN-1] == tail_reg)
        begin
            acc = 0;
            for (k = 0; k < NUM_POS; k++)
                acc += (longint'(win_bytes[DIGIT_POS[k]]) - 48) * DIGIT_WT[k];
            cmd.known = (win_bytes[1] >= ASCII_A) && (win_bytes[1] <= ASCII_O);
            cmd.idx   = cmd.known ? 4'(win_bytes[1] - ASCII_A) : GAIN_INDEX_UNKNOWN;
            cmd.value = GAIN_W'(acc);
            expected_cmds.push_back(cmd);
            win_fill = 0;
            return;
        end
        // Drop bytes up to the next header byte
        skip = 0;
        for (k = 1; k < FRAME_LEN; k++)
            if (skip == 0 && win_bytes[k] == hdr_reg)
                skip = k;
        if (skip > 0)
        begin
            for (k = 0; k < FRAME_LEN - skip; k++)
                win_bytes[k] = win_bytes[k + skip];
            win_fill = FRAME_LEN - skip;
        end
        else
            win_fill = 0;
    endfunction

    // Entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_byte(frame_buf[k]);
    endtask

    task automatic compose_frame(input logic [7:0] sel, input logic [7:0] dig [NUM_POS],
                                 input logic [7:0] sep);
        int k;
        frame_buf[0]           = hdr_reg;
        frame_buf[1]           = sel;
        frame_buf[5]           = sep;
        frame_buf[FRAME_LEN-1] = tail_reg;
        for (k = 0; k < NUM_POS; k++)
            frame_buf[DIGIT_POS[k]] = dig[k];
    endtask

    task automatic wait_drained();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (expected_cmds.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_HEADER)
            hdr_reg = value;
        else
            tail_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [7:0] hdr, input logic [7:0] tail);
        wait_drained();
        write_register(CFG_HEADER, hdr);
        write_register(CFG_TAIL, tail);
    endtask

    // Mostly well-formed frames with random content, plus broken ones and noise
    task automatic send_random_unit();
        int         pick;
        int         k;
        logic [7:0] dig [NUM_POS];
        logic [7:0] sel;
        logic [7:0] sep;
        pick = $urandom_range(0, 99);
        for (k = 0; k < NUM_POS; k++)
            dig[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                 : 8'(ASCII_ZERO + $urandom_range(0, 9));
        sel = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(ASCII_A + $urandom_range(0, 14));
        sep = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h2E;
        compose_frame(sel, dig, sep);
        if (pick < 70)
            send_frame(FRAME_LEN);
        else if (pick < 80)
        begin
            frame_buf[FRAME_LEN-1] = frame_buf[FRAME_LEN-1] ^ 8'($urandom_range(1, 255));
            send_frame(FRAME_LEN);
        end
        else if (pick < 90)
            send_frame($urandom_range(1, FRAME_LEN - 1));
        else
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
    endtask

    task automatic run_traffic(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_unit();
    endtask

    task automatic test_reset_registers();
        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(100);
    endtask

    task automatic test_directed_frames();
        set_registers(8'h24, 8'h0A);
        // Largest value: every digit byte at 255
        compose_frame(ASCII_A, '{6{8'hFF}}, 8'h2E);
        send_frame(FRAME_LEN);
        // Smallest value with an unknown selector
        compose_frame(8'hFF, '{6{8'h00}}, 8'h00);
        send_frame(FRAME_LEN);
        // Broken frame, then resync on a later header carrying the last selector
        compose_frame("B", '{"1", "2", "0", "0", "0", "0"}, 8'h2E);
        send_frame(4);
        compose_frame(ASCII_O, '{"3", "4", "5", "6", "7", "8"}, 8'h2E);
        send_frame(FRAME_LEN);
    endtask

    task automatic test_open_flow();
        set_registers(8'h00, 8'hFF);
        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(250);
    endtask

    task automatic test_sender_gaps();
        set_registers(8'hFF, 8'h00);
        idle_pct  = 70;
        stall_pct = 0;
        run_traffic(250);
    endtask

    task automatic test_receiver_stalls();
        set_registers(8'h24, 8'h0A);
        idle_pct  = 0;
        stall_pct = 70;
        run_traffic(250);
    endtask

    task automatic test_mixed_idling();
        // Header and tail share one value
        set_registers(8'h5A, 8'h5A);
        idle_pct  = 19;
        stall_pct = 19;
        run_traffic(250);
    endtask

    task automatic test_output_backpressure();
        int k;
        set_registers(8'h3A, 8'h0D);
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_start;
        for (k = 0; k < 8; k++)
        begin
            compose_frame(8'(ASCII_A + k), '{"9", "8", "7", "6", "5", "4"}, 8'h2E);
            send_frame(FRAME_LEN);
        end
        run_traffic(100);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_HEADER;
        cfg_data       = 8'h00;
        in_valid       = 1'b0;
        rx_byte        = 8'h00;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        win_fill       = 0;
        hdr_reg        = 8'h00;
        tail_reg       = 8'h00;
        for (int k = 0; k < FRAME_LEN; k++)
            win_bytes[k] = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_registers();
        test_directed_frames();
        test_open_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_output_backpressure();

        stall_pct = 0;
        wait_drained();
        if (expected_cmds.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_cmds.size());
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
